>>> hdl/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

   localparam int DELAY_WORDS   = 1024;
   localparam int SINE_ENTRIES  = 1024;

   localparam int DELAY_AW      = $clog2(DELAY_WORDS);
   localparam int SINE_AW       = $clog2(SINE_ENTRIES);
   localparam int QTR_ENTRIES   = SINE_ENTRIES / 4;
   localparam int QTR_AW        = SINE_AW - 2;
   localparam int QTR_IW        = QTR_AW + 1;
   localparam int T_SHIFT       = 16 - SINE_AW;

   localparam int SAMPLE_W      = 17;
   localparam int MEM_W         = 2 * SAMPLE_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int DELAY_FIELD_W = 10;
   localparam int PHASE_W       = 32;
   localparam int Q14_FRAC      = 14;
   localparam int Q14_ONE       = 16384;
   localparam int SINE_W        = 15;
   localparam int UNIT_W        = 16;
   localparam int PROD_W        = DELAY_FIELD_W + UNIT_W;
   localparam int SCALED_W      = PROD_W - Q14_FRAC;
   localparam int DLY_W         = 13;
   localparam int IDX_CALC_W    = DELAY_AW + DLY_W;

   localparam logic [DELAY_FIELD_W-1:0] BASE_DELAY_RST   = DELAY_FIELD_W'(264);
   localparam logic [DELAY_FIELD_W-1:0] MOD_DEPTH_RST    = DELAY_FIELD_W'(176);
   localparam logic [PHASE_W-1:0]       PHASE_STEP_A_RST = PHASE_W'(29217);
   localparam logic [PHASE_W-1:0]       PHASE_STEP_B_RST = PHASE_W'(38957);
   localparam logic [PHASE_W-1:0]       PHASE_B_RST      = 32'hC000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_DELAY   = 2'd0,
      CSR_MOD_DEPTH    = 2'd1,
      CSR_PHASE_STEP_A = 2'd2,
      CSR_PHASE_STEP_B = 2'd3
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SINE_W-1:0] sine_tab_type [QTR_ENTRIES+1];

   // quarter-wave Q14 sine, polynomial evaluated at elaboration
   function automatic sine_tab_type make_sine_tab();
      sine_tab_type tab;
      longint t;
      longint t2;
      longint inner;
      longint s;
      for (int m = 0; m <= QTR_ENTRIES; m++) begin
         t = longint'(m) << T_SHIFT;
         t2 = (t * t) >>> Q14_FRAC;
         inner = 10584 - ((t2 * 1302) >>> Q14_FRAC);
         inner = 25736 - ((t2 * inner) >>> Q14_FRAC);
         s = (t * inner) >>> Q14_FRAC;
         if (s > Q14_ONE) begin
            s = Q14_ONE;
         end
         tab[m] = SINE_W'(s);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = make_sine_tab();

   // average of two taps, floor, negative full scale pulled in by one
   function automatic sample_type mix_taps(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W:0] sum;
      sample_type avg;
      sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      avg = sum[SAMPLE_W:1];
      if (avg == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
         avg = {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};
      end
      return avg;
   endfunction

endpackage

>>> hdl/stc_req_if.sv
`timescale 1ns / 1ps

interface stc_req_if
   import stc_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type left_sample;
   sample_type right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

>>> hdl/stc_rsp_if.sv
`timescale 1ns / 1ps

interface stc_rsp_if
   import stc_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

>>> hdl/stc_ram.sv
`timescale 1ns / 1ps

module stc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the word held before a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/stereo_two_tap_chorus.sv
`timescale 1ns / 1ps

// Stereo two-tap chorus.
// req_if carries one stereo sample pair per request; rsp_if returns one
// chorus pair per request, in order. Both use valid/ready; a transfer
// happens on a clock edge with both high. csr_wr_en/csr_index/csr_wr_data
// write base_delay, mod_depth, phase_step_a and phase_step_b (indexes 0..3),
// one register per edge. The user must write them only while no request is
// in flight; the block itself does not enforce it. A request passes the tap
// a read, the tap b read and the mix stage into the output register. The two
// tap reads of a request share the single read port of the delay memory, so
// requests are not taken back to back. A register write holds req_if.ready
// low while the tap delays settle. Reset (synchronous, active high) restores
// the register defaults and the LFO phases, then zeroes the delay memory
// with req_if.ready low.
// When rsp_if is stalled, one more result is held in a skid stage; after
// that req_if.ready drops until the receiver takes a result.
module stereo_two_tap_chorus
   import stc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   stc_req_if.sink               req_if,
   stc_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   function automatic logic [UNIT_W-1:0] lfo_unit(input logic [PHASE_W-1:0] phase);
      logic [1:0]        quad;
      logic [QTR_IW-1:0] m;
      logic [SINE_W-1:0] s;
      quad = phase[PHASE_W-1 -: 2];
      m = {1'b0, phase[PHASE_W-3 -: QTR_AW]};
      if (quad[0]) begin
         m = QTR_IW'(QTR_ENTRIES) - m;
      end
      s = SINE_TAB[m];
      return quad[1] ? (UNIT_W'(Q14_ONE) - UNIT_W'(s)) : (UNIT_W'(Q14_ONE) + UNIT_W'(s));
   endfunction

   logic [DELAY_FIELD_W-1:0] base_ff, base_in;
   logic [DELAY_FIELD_W-1:0] depth_ff, depth_in;
   logic [PHASE_W-1:0]       step_a_ff, step_a_in;
   logic [PHASE_W-1:0]       step_b_ff, step_b_in;
   logic [PHASE_W-1:0]       phase_a_ff, phase_a_in;
   logic [PHASE_W-1:0]       phase_b_ff, phase_b_in;
   logic [DELAY_AW-1:0]      wp_ff, wp_in;
   logic                     clr_ff, clr_in;
   logic [DELAY_AW-1:0]      clr_cnt_ff, clr_cnt_in;

   logic [UNIT_W-1:0]        u_a_ff, u_b_ff;
   logic                     u_vld_ff;
   logic [PROD_W-1:0]        prod_a, prod_b;
   logic [DLY_W-1:0]         dly_a_in, dly_b_in;
   logic signed [DLY_W-1:0]  dly_a_ff, dly_b_ff;
   logic                     d_vld_ff, d_vld_in;

   logic [IDX_CALC_W-1:0]    diff_a, diff_b;
   logic [DELAY_AW-1:0]      ia, ib_ff;
   logic                     rd_a_ff, rd_b_ff;
   logic                     fwd_ff;
   logic [MEM_W-1:0]         samp_ff;
   logic [MEM_W-1:0]         tap_a_ff;
   logic [MEM_W-1:0]         ram_rd_data;
   logic                     ram_wr_en;
   logic [DELAY_AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [MEM_W-1:0]         ram_wr_data;

   logic                     mix_vld_ff, mix_vld_in;
   sample_type               mix_l_ff, mix_r_ff;
   logic                     out_vld_ff, out_vld_in;
   sample_type               out_l_ff, out_r_ff;
   logic [1:0]               occ_ff, occ_in;

   logic                     accept;
   logic                     rsp_fire;
   logic                     mix_move;
   logic [MEM_W-1:0]         req_word;

   assign accept   = req_if.valid & req_if.ready;
   assign rsp_fire = out_vld_ff & rsp_if.ready;
   assign mix_move = mix_vld_ff & (~out_vld_ff | rsp_if.ready);
   assign req_word = {req_if.left_sample, req_if.right_sample};

   assign req_if.ready = d_vld_ff & ~clr_ff & ~rd_a_ff & ((occ_ff != 2'd2) | rsp_fire);

   // configuration registers
   always_comb begin
      base_in   = base_ff;
      depth_in  = depth_ff;
      step_a_in = step_a_ff;
      step_b_in = step_b_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_DELAY:   base_in   = csr_wr_data[DELAY_FIELD_W-1:0];
            CSR_MOD_DEPTH:    depth_in  = csr_wr_data[DELAY_FIELD_W-1:0];
            CSR_PHASE_STEP_A: step_a_in = csr_wr_data[PHASE_W-1:0];
            CSR_PHASE_STEP_B: step_b_in = csr_wr_data[PHASE_W-1:0];
            default:          base_in   = base_ff;
         endcase
      end
   end

   // LFO phases, write pointer, memory clear sweep
   always_comb begin
      phase_a_in = accept ? (phase_a_ff + step_a_ff) : phase_a_ff;
      phase_b_in = accept ? (phase_b_ff + step_b_ff) : phase_b_ff;
      wp_in      = accept ? (wp_ff + DELAY_AW'(1)) : wp_ff;
      clr_cnt_in = clr_ff ? (clr_cnt_ff + DELAY_AW'(1)) : clr_cnt_ff;
      clr_in     = clr_ff & (clr_cnt_ff != DELAY_AW'(DELAY_WORDS - 1));
   end

   // tap delays: base + floor(depth * sine), kept for the next request
   always_comb begin
      prod_a   = PROD_W'(depth_ff) * PROD_W'(u_a_ff);
      prod_b   = PROD_W'(depth_ff) * PROD_W'(u_b_ff);
      dly_a_in = DLY_W'(base_ff) + DLY_W'(prod_a[PROD_W-1:Q14_FRAC]) - DLY_W'(depth_ff);
      dly_b_in = DLY_W'(base_ff) + DLY_W'(prod_b[PROD_W-1:Q14_FRAC]) - DLY_W'(depth_ff);
      d_vld_in = u_vld_ff & ~accept & ~csr_wr_en;
   end

   always_comb begin
      diff_a = IDX_CALC_W'(wp_ff)
               - {{(IDX_CALC_W-DLY_W){dly_a_ff[DLY_W-1]}}, dly_a_ff};
      diff_b = IDX_CALC_W'(wp_ff)
               - {{(IDX_CALC_W-DLY_W){dly_b_ff[DLY_W-1]}}, dly_b_ff};
      ia     = diff_a[DELAY_AW-1:0];
   end

   // memory port: sweep or sample write; tap a read with the write, tap b next
   always_comb begin
      ram_wr_en   = clr_ff | accept;
      ram_wr_addr = clr_ff ? clr_cnt_ff : wp_ff;
      ram_wr_data = clr_ff ? '0 : req_word;
      ram_rd_addr = rd_a_ff ? ib_ff : ia;
   end

   stc_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DELAY_WORDS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      mix_vld_in = rd_b_ff | (mix_vld_ff & ~mix_move);
      if (mix_move) begin
         out_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
      occ_in = occ_ff + 2'(accept) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_DELAY_RST;
         depth_ff   <= MOD_DEPTH_RST;
         step_a_ff  <= PHASE_STEP_A_RST;
         step_b_ff  <= PHASE_STEP_B_RST;
         phase_a_ff <= '0;
         phase_b_ff <= PHASE_B_RST;
         wp_ff      <= '0;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         u_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         rd_a_ff    <= 1'b0;
         rd_b_ff    <= 1'b0;
         mix_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         occ_ff     <= '0;
      end else begin
         base_ff    <= base_in;
         depth_ff   <= depth_in;
         step_a_ff  <= step_a_in;
         step_b_ff  <= step_b_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         wp_ff      <= wp_in;
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         u_vld_ff   <= 1'b1;
         d_vld_ff   <= d_vld_in;
         rd_a_ff    <= accept;
         rd_b_ff    <= rd_a_ff;
         mix_vld_ff <= mix_vld_in;
         out_vld_ff <= out_vld_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      u_a_ff   <= lfo_unit(phase_a_in);
      u_b_ff   <= lfo_unit(phase_b_in);
      dly_a_ff <= dly_a_in;
      dly_b_ff <= dly_b_in;
      if (accept) begin
         ib_ff   <= diff_b[DELAY_AW-1:0];
         fwd_ff  <= (ia == wp_ff);
         samp_ff <= req_word;
      end
      if (rd_a_ff) begin
         tap_a_ff <= fwd_ff ? samp_ff : ram_rd_data;
      end
      if (rd_b_ff) begin
         mix_l_ff <= mix_taps(tap_a_ff[MEM_W-1 -: SAMPLE_W], ram_rd_data[MEM_W-1 -: SAMPLE_W]);
         mix_r_ff <= mix_taps(tap_a_ff[SAMPLE_W-1:0], ram_rd_data[SAMPLE_W-1:0]);
      end
      if (mix_move) begin
         out_l_ff <= mix_l_ff;
         out_r_ff <= mix_r_ff;
      end
   end

   assign rsp_if.valid     = out_vld_ff;
   assign rsp_if.left_out  = out_l_ff;
   assign rsp_if.right_out = out_r_ff;

endmodule

>>> verif/stereo_chorus_checker.sv
`timescale 1ns / 1ps

module stereo_chorus_checker
   import stc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   stc_req_if                    req_mon,
   stc_rsp_if                    rsp_mon,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_pair;

   sample_type                 left_hist [DELAY_WORDS];
   sample_type                 right_hist [DELAY_WORDS];
   logic [DELAY_AW-1:0]        wr_ptr;
   logic [PHASE_W-1:0]         phase_a;
   logic [PHASE_W-1:0]         phase_b;
   logic [DELAY_FIELD_W-1:0]   base_dly;
   logic [DELAY_FIELD_W-1:0]   depth;
   logic [PHASE_W-1:0]         step_a;
   logic [PHASE_W-1:0]         step_b;
   stereo_pair                 pairs_due [$];
   int                         fail_count = 0;
   int                         pending_n = 0;

   assign mismatches  = fail_count;
   assign outstanding = pending_n;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // Q14 sine from the table index held in the top phase bits
   function automatic int q14_sine(input logic [PHASE_W-1:0] ph);
      longint idx;
      longint frac;
      longint t;
      longint t2;
      longint poly;
      longint s;
      idx  = longint'(ph) >> (PHASE_W - SINE_AW);
      frac = ((idx << 16) / SINE_ENTRIES) & 16'hFFFF;
      t    = frac & 16'h3FFF;
      if (frac[14]) begin
         t = Q14_ONE - t;
      end
      t2   = (t * t) >> Q14_FRAC;
      poly = 10584 - ((t2 * 1302) >> Q14_FRAC);
      poly = 25736 - ((t2 * poly) >> Q14_FRAC);
      s    = (t * poly) >> Q14_FRAC;
      if (s > Q14_ONE) begin
         s = Q14_ONE;
      end
      return frac[15] ? -int'(s) : int'(s);
   endfunction

   // delay can go negative or past the memory; the address wraps
   function automatic logic [DELAY_AW-1:0] tap_addr(input int sine);
      longint dly;
      dly = longint'(base_dly) - longint'(depth)
            + ((longint'(depth) * longint'(sine + Q14_ONE)) >>> Q14_FRAC);
      return DELAY_AW'(longint'(wr_ptr) - dly);
   endfunction

   function automatic sample_type avg_clip(input sample_type a, input sample_type b);
      int avg;
      avg = (int'(a) + int'(b)) >>> 1;
      if (avg < -65535) begin
         avg = -65535;
      end
      return sample_type'(avg);
   endfunction

   function automatic stereo_pair chorus_step(input sample_type l, input sample_type r);
      logic [DELAY_AW-1:0] ta;
      logic [DELAY_AW-1:0] tb;
      stereo_pair          res;
      left_hist[wr_ptr]  = l;
      right_hist[wr_ptr] = r;
      ta = tap_addr(q14_sine(phase_a));
      tb = tap_addr(q14_sine(phase_b));
      res.left  = avg_clip(left_hist[ta], left_hist[tb]);
      res.right = avg_clip(right_hist[ta], right_hist[tb]);
      wr_ptr  = wr_ptr + 1'b1;
      phase_a = phase_a + step_a;
      phase_b = phase_b + step_b;
      return res;
   endfunction

   always @(posedge clock) begin
      stereo_pair want;
      if (reset) begin
         foreach (left_hist[i]) begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
         end
         wr_ptr   = '0;
         phase_a  = '0;
         phase_b  = PHASE_B_RST;
         base_dly = BASE_DELAY_RST;
         depth    = MOD_DEPTH_RST;
         step_a   = PHASE_STEP_A_RST;
         step_b   = PHASE_STEP_B_RST;
         pairs_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BASE_DELAY:   base_dly = csr_wr_data[DELAY_FIELD_W-1:0];
               CSR_MOD_DEPTH:    depth = csr_wr_data[DELAY_FIELD_W-1:0];
               CSR_PHASE_STEP_A: step_a = csr_wr_data;
               CSR_PHASE_STEP_B: step_b = csr_wr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            pairs_due.push_back(chorus_step(req_mon.left_sample, req_mon.right_sample));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pairs_due.size() == 0) begin
               report_mismatch("result with no request pending");
            end else begin
               want = pairs_due.pop_front();
               if (rsp_mon.left_out !== want.left) begin
                  report_mismatch($sformatf("left_out %0d, expected %0d",
                                            rsp_mon.left_out, want.left));
               end
               if (rsp_mon.right_out !== want.right) begin
                  report_mismatch($sformatf("right_out %0d, expected %0d",
                                            rsp_mon.right_out, want.right));
               end
            end
         end
      end
      pending_n = pairs_due.size();
   end

endmodule

>>> verif/stereo_two_tap_chorus_tb.sv
`timescale 1ns / 1ps

module stereo_two_tap_chorus_tb;
   import stc_pkg::*;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_REQUESTS  = 73;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  no_idle;
   int                    mismatches;
   int                    outstanding;
   int                    stall_cycles;

   stc_req_if req_ch ();
   stc_rsp_if rsp_ch ();

   stereo_two_tap_chorus u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   stereo_chorus_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 17);
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("stereo_two_tap_chorus verification failed");
      $finish;
   end

   task automatic send_pair(input sample_type l, input sample_type r);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= l;
      req_ch.right_sample <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // upper bits of the 10-bit fields carry junk; the block must mask them
   task automatic program_chorus(input int unsigned base, input int unsigned depth,
                                 input logic [PHASE_W-1:0] step_a,
                                 input logic [PHASE_W-1:0] step_b);
      hold_until_drained();
      write_reg(CSR_BASE_DELAY, {22'($urandom()), 10'(base)});
      write_reg(CSR_MOD_DEPTH, {22'($urandom()), 10'(depth)});
      write_reg(CSR_PHASE_STEP_A, step_a);
      write_reg(CSR_PHASE_STEP_B, step_b);
   endtask

   function automatic int unsigned pick_delay_field();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 1023;
         default: return $urandom_range(1023);
      endcase
   endfunction

   function automatic logic [PHASE_W-1:0] pick_step();
      case ($urandom_range(5))
         0:       return 32'hFFFF_FFFF;
         1:       return '0;
         2:       return 32'($urandom_range(1023)) << 22;
         3:       return $urandom();
         default: return $urandom_range(200000);
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return sample_type'(-65536);
         1:       return sample_type'(65535);
         2:       return sample_type'(int'($urandom_range(64)) - 32);
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_BASE_DELAY;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.left_sample  = '0;
      req_ch.right_sample = '0;
      no_idle             = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults
      send_pair(-65536, 65535);
      send_pair(65535, -65536);
      send_pair(-1, 1);
      send_pair(0, 0);

      // zero delay: both taps read the request just written, -65536 clips
      program_chorus(0, 0, 32'h0000_1000, 32'h8000_0000);
      send_pair(-65536, -65536);
      send_pair(65535, 65535);
      send_pair(-65536, 65535);
      send_pair(0, -1);
      send_pair(1, 0);
      send_pair(-65535, -2);

      // negative delays, every sine quadrant
      program_chorus(0, 1023, 32'h4000_0000, 32'h2000_0000);
      repeat (8) send_pair(pick_sample(), pick_sample());

      // largest base delay and depth fields
      program_chorus(1023, 1023, 32'hFFFF_FFFF, 32'h0000_0000);
      repeat (5) send_pair(pick_sample(), pick_sample());

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_chorus(pick_delay_field(), pick_delay_field(), pick_step(), pick_step());
         no_idle = (p == 5);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(59) == 0) begin
               hold_until_drained();
            end
            send_pair(pick_sample(), pick_sample());
         end
      end
      no_idle = 1'b0;

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("stereo_two_tap_chorus verification clean");
      end else begin
         $display("stereo_two_tap_chorus verification failed");
      end
      $finish;
   end

endmodule

>>> stereo_two_tap_chorus.f
hdl/stc_pkg.sv
hdl/stc_req_if.sv
hdl/stc_rsp_if.sv
hdl/stc_ram.sv
hdl/stereo_two_tap_chorus.sv
verif/stereo_chorus_checker.sv
verif/stereo_two_tap_chorus_tb.sv
